// ----- hdl/sha512m_pkg.sv -----
package sha512m_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumHash   = 8;
  localparam int unsigned WinDepth  = 16;
  // First round whose schedule window no longer has to produce a new word.
  localparam int unsigned LastExpand = NumRounds - WinDepth;

  // Padding of a 32-byte message: the marker bit right after the message
  // and the bit length in the last word.
  localparam logic [WordW-1:0] PadWord = 64'h8000000000000000;
  localparam logic [WordW-1:0] LenWord = 64'h0000000000000100;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumHash-1:0][WordW-1:0] hash_t;
  typedef logic [WinDepth-1:0][WordW-1:0] win_t;

  localparam word_t InitHash [NumHash] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RoundK [NumRounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

// ----- hdl/sha512m_msg_if.sv -----
interface sha512m_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_word_0;
  logic [63:0] msg_word_1;
  logic [63:0] msg_word_2;
  logic [63:0] msg_word_3;

  modport source (
    output valid, msg_word_0, msg_word_1, msg_word_2, msg_word_3,
    input  ready
  );
  modport sink (
    input  valid, msg_word_0, msg_word_1, msg_word_2, msg_word_3,
    output ready
  );
endinterface

// ----- hdl/sha512m_dig_if.sv -----
interface sha512m_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word_0;
  logic [63:0] digest_word_1;
  logic [63:0] digest_word_2;
  logic [63:0] digest_word_3;
  logic [63:0] digest_word_4;
  logic [63:0] digest_word_5;
  logic [63:0] digest_word_6;
  logic [63:0] digest_word_7;

  modport source (
    output valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
           digest_word_4, digest_word_5, digest_word_6, digest_word_7,
    input  ready
  );
  modport sink (
    input  valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
           digest_word_4, digest_word_5, digest_word_6, digest_word_7,
    output ready
  );
endinterface

// ----- hdl/sha512m_round.sv -----
module sha512m_round
  import sha512m_pkg::*;
#(
  parameter int unsigned RoundIdx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  hash_t state_i,
  input  win_t  win_i,
  output logic  valid_o,
  output hash_t state_o,
  output win_t  win_o
);

  logic  valid_q;
  hash_t state_d, state_q;
  win_t  win_d, win_q;
  word_t t1, t2, ch, maj, new_w;

  // Word 0 of the window is the schedule word of this round.
  always_comb begin
    ch  = (state_i[4] & state_i[5]) ^ (~state_i[4] & state_i[6]);
    maj = (state_i[0] & state_i[1]) ^ (state_i[0] & state_i[2]) ^
          (state_i[1] & state_i[2]);
    t1  = state_i[7] + big_sig1(state_i[4]) + ch + RoundK[RoundIdx] + win_i[0];
    t2  = big_sig0(state_i[0]) + maj;
    state_d[0] = t1 + t2;
    state_d[1] = state_i[0];
    state_d[2] = state_i[1];
    state_d[3] = state_i[2];
    state_d[4] = state_i[3] + t1;
    state_d[5] = state_i[4];
    state_d[6] = state_i[5];
    state_d[7] = state_i[6];
  end

  generate
    if (RoundIdx < LastExpand) begin : g_expand
      assign new_w = small_sig1(win_i[14]) + win_i[9] + small_sig0(win_i[1]) + win_i[0];
    end else begin : g_tail
      // Words beyond the last round are never consumed.
      assign new_w = '0;
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < WinDepth - 1; i++) begin
      win_d[i] = win_i[i+1];
    end
    win_d[WinDepth-1] = new_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      win_q   <= win_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign win_o   = win_q;

endmodule

// ----- hdl/sha512m_final.sv -----
module sha512m_final
  import sha512m_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  hash_t state_i,
  output logic  valid_o,
  output hash_t digest_o
);

  logic  valid_q;
  hash_t digest_d, digest_q;

  // The initial hash value is added back in, word by word.
  always_comb begin
    for (int i = 0; i < NumHash; i++) begin
      digest_d[i] = state_i[i] + InitHash[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      digest_q <= digest_d;
    end
  end

  assign valid_o  = valid_q;
  assign digest_o = digest_q;

endmodule

// ----- hdl/sha512_of_256bit_message.sv -----
// SHA-512 digest of a fixed 32-byte message, fully unrolled.
//
// Input channel msg_i: one beat carries the whole message as four big-endian
// 64-bit words. Output channel dig_o: one beat carries the eight digest words,
// word 0 first in byte order. Both use a valid/ready handshake; a beat moves
// at a rising edge where both are high.
// Each of the 80 compression rounds owns one register stage, and the message
// schedule travels through the stages as a sliding window of 16 words. A final
// stage adds the initial hash value back and is the output register.
// An accepted message passes through the round stages and the final stage
// before its digest is shown on dig_o. Throughput is one message per cycle
// unless dig_o stalls; the round adder chain in a stage sets the clock period.
// The whole pipeline advances together: while dig_o holds a beat that is not
// taken, every stage holds, msg_i.ready drops, and nothing is lost or repeated.
// Bubbles between messages flow through as stages with their valid bit clear.
// Reset clears every valid bit, so the block comes up empty and ready.
module sha512_of_256bit_message
  import sha512m_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sha512m_msg_if.sink   msg_i,
  sha512m_dig_if.source dig_o
);

  logic                 adv;
  logic [NumRounds:0]   vld;
  hash_t                st  [NumRounds+1];
  win_t                 win [NumRounds];
  hash_t                digest;
  logic                 dig_valid;

  // One enable for every stage: move on when the output register is free.
  assign adv         = !dig_valid || dig_o.ready;
  assign msg_i.ready = adv;

  // The single padded block for a 256-bit message: the length word on top,
  // ten zero words, the padding word, then the four message words.
  assign win[0] = {LenWord, {10{64'h0}}, PadWord, msg_i.msg_word_3,
                   msg_i.msg_word_2, msg_i.msg_word_1, msg_i.msg_word_0};
  assign st[0]  = {InitHash[7], InitHash[6], InitHash[5], InitHash[4],
                   InitHash[3], InitHash[2], InitHash[1], InitHash[0]};
  assign vld[0] = msg_i.valid;

  generate
    for (genvar r = 0; r < NumRounds; r++) begin : g_round
      if (r < NumRounds - 1) begin : g_mid
        sha512m_round #(.RoundIdx(r)) u_round (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .en_i    (adv),
          .valid_i (vld[r]),
          .state_i (st[r]),
          .win_i   (win[r]),
          .valid_o (vld[r+1]),
          .state_o (st[r+1]),
          .win_o   (win[r+1])
        );
      end else begin : g_last
        // The schedule window is spent after the last round.
        sha512m_round #(.RoundIdx(r)) u_round (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .en_i    (adv),
          .valid_i (vld[r]),
          .state_i (st[r]),
          .win_i   (win[r]),
          .valid_o (vld[r+1]),
          .state_o (st[r+1]),
          .win_o   ()
        );
      end
    end
  endgenerate

  sha512m_final u_final (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (vld[NumRounds]),
    .state_i  (st[NumRounds]),
    .valid_o  (dig_valid),
    .digest_o (digest)
  );

  assign dig_o.valid         = dig_valid;
  assign dig_o.digest_word_0 = digest[0];
  assign dig_o.digest_word_1 = digest[1];
  assign dig_o.digest_word_2 = digest[2];
  assign dig_o.digest_word_3 = digest[3];
  assign dig_o.digest_word_4 = digest[4];
  assign dig_o.digest_word_5 = digest[5];
  assign dig_o.digest_word_6 = digest[6];
  assign dig_o.digest_word_7 = digest[7];

`ifndef SYNTHESIS
  // An accepted message occupies the first round stage on the next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_i.valid && msg_i.ready |=> vld[1])
    else $error("accepted message did not enter the first round stage");

  // While the output is stalled, no stage gains or loses an item.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld[NumRounds:1]) && dig_valid)
    else $error("pipeline valid bits changed during a stall");

  // When the pipeline advances, every valid bit moves down one stage.
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> vld[NumRounds:1] == $past(vld[NumRounds-1:0]))
    else $error("valid bits did not shift with the pipeline");

  // A digest only appears when the last round stage held an item.
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dig_valid) |-> $past(vld[NumRounds]))
    else $error("digest became valid without a finished item");
`endif

endmodule

// ----- test/tb_sha512_of_256bit_message.sv -----
`timescale 1ns / 1ps

module tb_sha512_of_256bit_message;
  import sha512m_pkg::*;

  // Number of round stages; the final wait for stray digest beats is sized from it.
  localparam int unsigned PipeLatency = 80;

  // The receiver's long hold-off is several times the pipeline depth, so every
  // stage fills and the input side has to stall for a good while.
  localparam int unsigned LongHoldCycles = 400;

  // Random traffic is split into phases; the sizes add up to about 1100 beats
  // together with the directed table.
  localparam int unsigned NumDirected   = 18;
  localparam int unsigned NumFillPhase  = 300;
  localparam int unsigned NumMixedPhase = 400;
  localparam int unsigned NumBurstPhase = 150;
  localparam int unsigned NumTailPhase  = 232;

  // Watchdog, in ns. The slowest correct run (sender gaps, 20 percent receiver
  // duty, one long hold-off and three drains) stays well below this limit.
  localparam int unsigned RunLimitNs = 5_000_000;

  // Standard SHA-512 round constants and initial hash value, kept here so the
  // digest predictor does not lean on anything in the design's package.
  localparam word_t RoundConst [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t IvWords [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  // Directed messages, one row per beat, packed as {word 0, word 1, word 2,
  // word 3}. A SHA-512 digest cannot be read off by eye for any of them, so
  // every row is checked against the predictor rather than a typed-in value.
  // The rows cover the all-zero and all-one extremes, alternating bit
  // patterns, a single set bit at either end, each word saturated on its own,
  // and messages that mimic the padding word and the length word.
  localparam logic [255:0] DirectedMsgs [NumDirected] = '{
    256'h0000000000000000_0000000000000000_0000000000000000_0000000000000000,
    256'hffffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffff,
    256'h5555555555555555_5555555555555555_5555555555555555_5555555555555555,
    256'haaaaaaaaaaaaaaaa_aaaaaaaaaaaaaaaa_aaaaaaaaaaaaaaaa_aaaaaaaaaaaaaaaa,
    256'h8000000000000000_0000000000000000_0000000000000000_0000000000000000,
    256'h0000000000000000_0000000000000000_0000000000000000_0000000000000001,
    256'hffffffffffffffff_0000000000000000_0000000000000000_0000000000000000,
    256'h0000000000000000_ffffffffffffffff_0000000000000000_0000000000000000,
    256'h0000000000000000_0000000000000000_ffffffffffffffff_0000000000000000,
    256'h0000000000000000_0000000000000000_0000000000000000_ffffffffffffffff,
    256'h0123456789abcdef_fedcba9876543210_0f0f0f0f0f0f0f0f_f0f0f0f0f0f0f0f0,
    256'h0001020304050607_08090a0b0c0d0e0f_1011121314151617_18191a1b1c1d1e1f,
    256'h8000000000000000_8000000000000000_8000000000000000_8000000000000000,
    256'h0000000000000100_0000000000000100_0000000000000100_0000000000000100,
    256'h7fffffffffffffff_7fffffffffffffff_7fffffffffffffff_7fffffffffffffff,
    256'h0000000000000001_8000000000000000_0000000000000001_8000000000000000,
    256'hff00ff00ff00ff00_00ff00ff00ff00ff_ff00ff00ff00ff00_00ff00ff00ff00ff,
    256'hdeadbeefcafef00d_0badc0de8badf00d_feedfacec001d00d_1234567890abcdef
  };

  logic clk_i;
  logic rst_ni;

  sha512m_msg_if msg_if ();
  sha512m_dig_if dig_if ();

  sha512_of_256bit_message dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  // Digests still owed by the block, oldest first. Filled by the input
  // monitor at the accepting edge and drained by the output checker.
  hash_t digest_q [$];

  int unsigned msgs_sent;
  int unsigned digests_checked;
  int unsigned mismatches;
  int unsigned input_stalls;
  int unsigned long_holds;
  int unsigned drain_pauses;

  // Sender burst state, and the request that makes the receiver hold off.
  int unsigned burst_left;
  bit          gap_free;
  bit          long_hold_req;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Rotate right by n, 1 <= n <= 63, done on a doubled copy of the word.
  function automatic word_t ror64(input word_t x, input int unsigned n);
    logic [127:0] dbl;
    dbl = {x, x} >> n;
    return dbl[63:0];
  endfunction

  // Full SHA-512 of a 32-byte message: build the single padded block,
  // expand the schedule, run 80 rounds and add the initial hash back.
  function automatic hash_t sha512_of_block(input logic [255:0] msg);
    word_t sched [80];
    word_t st [8];
    word_t a, e, t1, t2;
    hash_t dig;
    for (int i = 0; i < 4; i++) sched[i] = msg[255 - 64*i -: 64];
    sched[4] = 64'h8000_0000_0000_0000;
    for (int i = 5; i < 15; i++) sched[i] = '0;
    sched[15] = 64'd256;
    for (int i = 16; i < 80; i++) begin
      sched[i] = (ror64(sched[i-2], 19) ^ ror64(sched[i-2], 61) ^ (sched[i-2] >> 6))
               + sched[i-7]
               + (ror64(sched[i-15], 1) ^ ror64(sched[i-15], 8) ^ (sched[i-15] >> 7))
               + sched[i-16];
    end
    for (int i = 0; i < 8; i++) st[i] = IvWords[i];
    for (int r = 0; r < 80; r++) begin
      a  = st[0];
      e  = st[4];
      t1 = st[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
         + ((e & st[5]) ^ (~e & st[6])) + RoundConst[r] + sched[r];
      t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
         + ((a & st[1]) ^ (a & st[2]) ^ (st[1] & st[2]));
      for (int i = 7; i > 0; i--) st[i] = st[i-1];
      // After the shift st[4] holds the old d, which takes t1.
      st[4] = st[4] + t1;
      st[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) dig[i] = st[i] + IvWords[i];
    return dig;
  endfunction

  // Mostly uniform words, with a share of zero, all-ones and single-bit
  // words so the carry chains also see their sparse and saturated corners.
  function automatic word_t random_word();
    word_t bit_mask;
    bit_mask = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return bit_mask;
      3: return ~bit_mask;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [255:0] random_message();
    return {random_word(), random_word(), random_word(), random_word()};
  endfunction

  // Offer one message and return at the edge where it is accepted. The sender
  // works in bursts; between bursts valid drops for a random gap, unless the
  // current phase runs gap-free. Valid is only ever lowered in a step where it
  // is not also raised.
  task automatic offer_message(input logic [255:0] msg);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gap_free ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        msg_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    {msg_if.msg_word_0, msg_if.msg_word_1, msg_if.msg_word_2, msg_if.msg_word_3} <= msg;
    msg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!msg_if.ready);
    msgs_sent++;
  endtask

  // Stop offering and wait until every owed digest has come back. At least
  // one edge passes, so the next offer never raises valid in this step.
  task automatic drain_digests();
    msg_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (digest_q.size() != 0);
    drain_pauses++;
  endtask

  // Input monitor. Values are sampled at the edge before any update in that
  // step lands, so a beat counts exactly when valid and ready were both high.
  always @(posedge clk_i) begin : msg_capture
    if (rst_ni && msg_if.valid) begin
      if (msg_if.ready) begin
        digest_q.push_back(sha512_of_block({msg_if.msg_word_0, msg_if.msg_word_1,
                                            msg_if.msg_word_2, msg_if.msg_word_3}));
      end else begin
        input_stalls++;
      end
    end
  end

  // Output checker: each accepted digest beat is compared word by word with
  // the oldest owed digest. A beat with nothing owed is a failure of its own.
  always @(posedge clk_i) begin : digest_check
    hash_t want;
    hash_t got;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      got = {dig_if.digest_word_7, dig_if.digest_word_6, dig_if.digest_word_5,
             dig_if.digest_word_4, dig_if.digest_word_3, dig_if.digest_word_2,
             dig_if.digest_word_1, dig_if.digest_word_0};
      if (digest_q.size() == 0) begin
        $error("digest beat with no message outstanding: word 0 = %h", got[0]);
        mismatches++;
      end else begin
        want = digest_q.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            $error("digest_word_%0d: expected %h, actual %h", i, want[i], got[i]);
            mismatches++;
          end
        end
        digests_checked++;
      end
    end
  end

  // Receiver. It switches between segments of always-ready, mostly-ready,
  // mostly-stalled and a fixed one-in-three stall pattern, so back-pressure
  // lands on every stage position of the pipeline. When asked, it holds ready
  // low for a long stretch, counted here, so the pipeline fills completely.
  initial begin : digest_sink
    int unsigned seg_left;
    int unsigned mode;
    int unsigned phase_cnt;
    seg_left  = 0;
    mode      = 0;
    phase_cnt = 0;
    dig_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        dig_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
        long_holds++;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(40, 200);
        end
        seg_left--;
        phase_cnt++;
        case (mode)
          0: dig_if.ready <= 1'b1;
          1: dig_if.ready <= ($urandom_range(0, 9) < 7);
          2: dig_if.ready <= ($urandom_range(0, 9) < 2);
          default: dig_if.ready <= (phase_cnt % 3 != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases with the long
  // receiver hold-off, a sender pause that lets the pipeline run dry, a
  // gap-free stretch, and a closing mixed phase.
  initial begin : stimulus
    msgs_sent       = 0;
    digests_checked = 0;
    mismatches      = 0;
    input_stalls    = 0;
    long_holds      = 0;
    drain_pauses    = 0;
    burst_left      = 0;
    gap_free        = 1'b0;
    long_hold_req   = 1'b0;

    rst_ni            <= 1'b0;
    msg_if.valid      <= 1'b0;
    msg_if.msg_word_0 <= '0;
    msg_if.msg_word_1 <= '0;
    msg_if.msg_word_2 <= '0;
    msg_if.msg_word_3 <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) offer_message(DirectedMsgs[i]);
    drain_digests();

    // The receiver holds off while the sender keeps pushing back to back:
    // the stages fill up and msg_i.ready has to drop until it lets go.
    long_hold_req = 1'b1;
    gap_free      = 1'b1;
    for (int i = 0; i < NumFillPhase; i++) offer_message(random_message());

    gap_free = 1'b0;
    for (int i = 0; i < NumMixedPhase; i++) offer_message(random_message());

    // Let the pipeline empty out completely before traffic resumes.
    drain_digests();

    gap_free = 1'b1;
    for (int i = 0; i < NumBurstPhase; i++) offer_message(random_message());

    gap_free = 1'b0;
    for (int i = 0; i < NumTailPhase; i++) offer_message(random_message());

    drain_digests();
    // Any digest beat that shows up now has no message behind it.
    repeat (PipeLatency + 20) @(posedge clk_i);

    $display("summary: %0d messages sent (%0d directed), %0d digests checked",
             msgs_sent, NumDirected, digests_checked);
    $display("summary: %0d input stall cycles, %0d long output hold-offs, %0d drains",
             input_stalls, long_holds, drain_pauses);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimitNs);
    $error("run did not finish in time, %0d digests still owed", digest_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sha512m_pkg.sv
hdl/sha512m_msg_if.sv
hdl/sha512m_dig_if.sv
hdl/sha512m_round.sv
hdl/sha512m_final.sv
hdl/sha512_of_256bit_message.sv
test/tb_sha512_of_256bit_message.sv
